[hw/rtl/tws_pkg.sv]
package tws_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ErrW     = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // command selector on the request channel
  localparam logic [FuncW-1:0] FUNC_LINK_RESET  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_SOFT_RESET  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_STATUS_RD   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_STATUS_WR   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_MEAS_TEMP   = 3'd4;
  localparam logic [FuncW-1:0] FUNC_MEAS_HUMID  = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHORT_DELAY = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_DELAY  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT     = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_TEMP_CODE   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_HUMID_CODE  = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_STAT_RD     = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_STAT_WR     = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_SOFT_RST    = 4'd7;

  localparam logic [ByteW-1:0]    SHORT_DELAY_RST = 8'd1;
  localparam logic [ByteW-1:0]    LONG_DELAY_RST  = 8'd5;
  localparam logic [TimeoutW-1:0] TIMEOUT_RST     = 16'hFFFF;
  localparam logic [ByteW-1:0]    TEMP_CODE_RST   = 8'd3;
  localparam logic [ByteW-1:0]    HUMID_CODE_RST  = 8'd5;
  localparam logic [ByteW-1:0]    STAT_RD_RST     = 8'd7;
  localparam logic [ByteW-1:0]    STAT_WR_RST     = 8'd6;
  localparam logic [ByteW-1:0]    SOFT_RST_RST    = 8'd30;

  localparam logic [ErrW-1:0] ERR_MAX = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]    short_delay;
    logic [ByteW-1:0]    long_delay;
    logic [TimeoutW-1:0] timeout;
    logic [ByteW-1:0]    temp_code;
    logic [ByteW-1:0]    humid_code;
    logic [ByteW-1:0]    stat_rd_code;
    logic [ByteW-1:0]    stat_wr_code;
    logic [ByteW-1:0]    soft_rst_code;
  } cfg_t;

  typedef struct packed {
    logic             sck;
    logic             data_drive_low;
    logic             busy_res;
    logic             done_res;
    logic [ErrW-1:0]  error_count;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic [ByteW-1:0] checksum_byte;
  } result_t;

endpackage

[hw/rtl/tws_ifs.sv]
interface tws_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [2:0] func;
  logic [7:0] status_value;
  logic       data_in;

  modport source (output valid, start_req, func, status_value, data_in, input ready);
  modport sink   (input valid, start_req, func, status_value, data_in, output ready);
endinterface

interface tws_out_if;
  logic       valid;
  logic       ready;
  logic       sck;
  logic       data_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] error_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] checksum_byte;

  modport source (output valid, sck, data_drive_low, busy_res, done_res, error_count,
                  first_byte, second_byte, checksum_byte, input ready);
  modport sink   (input valid, sck, data_drive_low, busy_res, done_res, error_count,
                  first_byte, second_byte, checksum_byte, output ready);
endinterface

interface tws_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tws_cfg_regs.sv]
module tws_cfg_regs import tws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        REG_SHORT_DELAY: cfg_d.short_delay   = data_i[ByteW-1:0];
        REG_LONG_DELAY:  cfg_d.long_delay    = data_i[ByteW-1:0];
        REG_TIMEOUT:     cfg_d.timeout       = data_i[TimeoutW-1:0];
        REG_TEMP_CODE:   cfg_d.temp_code     = data_i[ByteW-1:0];
        REG_HUMID_CODE:  cfg_d.humid_code    = data_i[ByteW-1:0];
        REG_STAT_RD:     cfg_d.stat_rd_code  = data_i[ByteW-1:0];
        REG_STAT_WR:     cfg_d.stat_wr_code  = data_i[ByteW-1:0];
        REG_SOFT_RST:    cfg_d.soft_rst_code = data_i[ByteW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_delay   <= SHORT_DELAY_RST;
      cfg_q.long_delay    <= LONG_DELAY_RST;
      cfg_q.timeout       <= TIMEOUT_RST;
      cfg_q.temp_code     <= TEMP_CODE_RST;
      cfg_q.humid_code    <= HUMID_CODE_RST;
      cfg_q.stat_rd_code  <= STAT_RD_RST;
      cfg_q.stat_wr_code  <= STAT_WR_RST;
      cfg_q.soft_rst_code <= SOFT_RST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/tws_seq.sv]
module tws_seq import tws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             tick_i,
  input  logic             start_req_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [ByteW-1:0] status_value_i,
  input  logic             data_in_i,
  output result_t          res_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_CR_INIT = 5'd1,
    PH_CR_HI   = 5'd2,
    PH_CR_LO   = 5'd3,
    PH_TS1     = 5'd4,
    PH_TS2     = 5'd5,
    PH_TS3     = 5'd6,
    PH_TS4     = 5'd7,
    PH_TS5     = 5'd8,
    PH_TS6     = 5'd9,
    PH_TS7     = 5'd10,
    PH_WB_SET  = 5'd11,
    PH_WB_HI   = 5'd12,
    PH_WB_ASET = 5'd13,
    PH_WB_AHI  = 5'd14,
    PH_WB_ALO  = 5'd15,
    PH_WAIT    = 5'd16,
    PH_RB_HI   = 5'd17,
    PH_RB_LO   = 5'd18,
    PH_RB_ACK  = 5'd19,
    PH_RB_C9   = 5'd20,
    PH_RB_C9LO = 5'd21
  } phase_e;

  localparam logic [3:0] CrPulses = 4'd9;
  localparam logic [3:0] ByteBits = 4'd8;

  function automatic logic [TimeoutW-1:0] load_ticks(phase_e p, cfg_t c);
    logic [TimeoutW-1:0] d;
    unique case (p)
      PH_TS4, PH_WB_HI, PH_RB_C9: d = {{(TimeoutW-ByteW){1'b0}}, c.long_delay};
      PH_WAIT:                    d = c.timeout;
      default:                    d = {{(TimeoutW-ByteW){1'b0}}, c.short_delay};
    endcase
    return (d == '0) ? TimeoutW'(1) : d;
  endfunction

  phase_e              ph_q, ph_d, ph0;
  logic [FuncW-1:0]    op_q, op_d, op0;
  logic [3:0]          bc_q, bc_d, bc0, bc_inc;
  logic [TimeoutW-1:0] dc_q, dc_d, dc0, dec;
  logic [ByteW-1:0]    sr_q, sr_d;
  logic [1:0]          bi_q, bi_d, bi0;
  logic [ByteW-1:0]    rb_q [3];
  logic [ByteW-1:0]    rb_d [3];
  logic [ErrW-1:0]     err_q, err_d, err0;
  logic [ByteW-1:0]    sv_q, sv_d;
  logic                start_go, fire, sck, drv;
  logic [ByteW-1:0]    cmd_code;

  always_comb begin
    unique case (op0)
      FUNC_SOFT_RESET: cmd_code = cfg_i.soft_rst_code;
      FUNC_STATUS_RD:  cmd_code = cfg_i.stat_rd_code;
      FUNC_STATUS_WR:  cmd_code = cfg_i.stat_wr_code;
      FUNC_MEAS_TEMP:  cmd_code = cfg_i.temp_code;
      default:         cmd_code = cfg_i.humid_code;
    endcase
  end

  always_comb begin
    start_go = (ph_q == PH_IDLE) && start_req_i && (func_i <= FUNC_MEAS_HUMID);

    // state as seen after a command start on this tick
    ph0  = ph_q;
    op0  = op_q;
    bc0  = bc_q;
    dc0  = dc_q;
    bi0  = bi_q;
    err0 = err_q;
    sv_d = sv_q;
    for (int i = 0; i < 3; i++) rb_d[i] = rb_q[i];
    if (start_go) begin
      ph0  = (func_i <= FUNC_SOFT_RESET) ? PH_CR_INIT : PH_TS1;
      op0  = func_i;
      bc0  = '0;
      bi0  = '0;
      err0 = '0;
      sv_d = status_value_i;
      dc0  = load_ticks(ph0, cfg_i);
      for (int i = 0; i < 3; i++) rb_d[i] = '0;
    end

    ph_d  = ph0;
    op_d  = op0;
    bc_d  = bc0;
    bi_d  = bi0;
    err_d = err0;
    sr_d  = sr_q;
    dc_d  = dc0;
    sck   = 1'b0;
    drv   = 1'b0;
    fire  = 1'b0;
    bc_inc = bc0 + 4'd1;
    dec   = (dc0 != '0) ? dc0 - TimeoutW'(1) : '0;

    if (ph0 != PH_IDLE) begin
      unique case (ph0)
        PH_CR_HI, PH_TS2, PH_TS3, PH_TS5, PH_TS6,
        PH_WB_HI, PH_WB_AHI, PH_RB_HI, PH_RB_C9: sck = 1'b1;
        default: sck = 1'b0;
      endcase
      unique case (ph0)
        PH_TS3, PH_TS4, PH_TS5:            drv = 1'b1;
        PH_WB_SET, PH_WB_HI:               drv = ~sr_q[ByteW-1];
        PH_RB_ACK, PH_RB_C9, PH_RB_C9LO:   drv = (bi0 != 2'd2);
        default:                           drv = 1'b0;
      endcase

      // the busy wait also ends early when the sensor pulls DATA low
      fire = (dec == '0) || ((ph0 == PH_WAIT) && !data_in_i);
      dc_d = dec;

      if (fire) begin
        unique case (ph0)
          PH_CR_INIT: begin
            bc_d = '0;
            ph_d = PH_CR_HI;
          end
          PH_CR_HI: ph_d = PH_CR_LO;
          PH_CR_LO: begin
            bc_d = bc_inc;
            ph_d = (bc_inc < CrPulses) ? PH_CR_HI : PH_TS1;
          end
          PH_TS1: ph_d = PH_TS2;
          PH_TS2: ph_d = PH_TS3;
          PH_TS3: ph_d = PH_TS4;
          PH_TS4: ph_d = PH_TS5;
          PH_TS5: ph_d = PH_TS6;
          PH_TS6: ph_d = PH_TS7;
          PH_TS7: begin
            if (op0 == FUNC_LINK_RESET) begin
              ph_d = PH_IDLE;
            end else begin
              bi_d = '0;
              sr_d = cmd_code;
              bc_d = '0;
              ph_d = PH_WB_SET;
            end
          end
          PH_WB_SET: ph_d = PH_WB_HI;
          PH_WB_HI: begin
            sr_d = {sr_q[ByteW-2:0], 1'b0};
            bc_d = bc_inc;
            ph_d = (bc_inc < ByteBits) ? PH_WB_SET : PH_WB_ASET;
          end
          PH_WB_ASET: ph_d = PH_WB_AHI;
          PH_WB_AHI: begin
            if (data_in_i && err0 < ERR_MAX) err_d = err0 + ErrW'(1);
            ph_d = PH_WB_ALO;
          end
          PH_WB_ALO: begin
            if (op0 == FUNC_STATUS_WR && bi0 == 2'd0) begin
              bi_d = 2'd1;
              sr_d = sv_q;
              bc_d = '0;
              ph_d = PH_WB_SET;
            end else if (op0 == FUNC_SOFT_RESET || op0 == FUNC_STATUS_WR) begin
              ph_d = PH_IDLE;
            end else if (op0 == FUNC_STATUS_RD) begin
              bi_d = '0;
              sr_d = '0;
              bc_d = '0;
              ph_d = PH_RB_HI;
            end else begin
              bi_d = '0;
              ph_d = PH_WAIT;
            end
          end
          PH_WAIT: begin
            // timeout with DATA still high counts one error
            if (data_in_i && err0 < ERR_MAX) err_d = err0 + ErrW'(1);
            sr_d = '0;
            bc_d = '0;
            ph_d = PH_RB_HI;
          end
          PH_RB_HI: begin
            sr_d = {sr_q[ByteW-2:0], data_in_i};
            ph_d = PH_RB_LO;
          end
          PH_RB_LO: begin
            bc_d = bc_inc;
            if (bc_inc < ByteBits) begin
              ph_d = PH_RB_HI;
            end else begin
              if (bi0 != 2'd3) rb_d[bi0] = sr_q;
              ph_d = (bi0 != 2'd2) ? PH_RB_ACK : PH_RB_C9;
            end
          end
          PH_RB_ACK: ph_d = PH_RB_C9;
          PH_RB_C9:  ph_d = PH_RB_C9LO;
          PH_RB_C9LO: begin
            if (bi0 >= 2'd2) begin
              ph_d = PH_IDLE;
            end else begin
              bi_d = (op0 == FUNC_STATUS_RD) ? 2'd2 : bi0 + 2'd1;
              sr_d = '0;
              bc_d = '0;
              ph_d = PH_RB_HI;
            end
          end
          default: ph_d = PH_IDLE;
        endcase
        dc_d = (ph_d == PH_IDLE) ? '0 : load_ticks(ph_d, cfg_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      op_q  <= '0;
      bc_q  <= '0;
      dc_q  <= '0;
      sr_q  <= '0;
      bi_q  <= '0;
      err_q <= '0;
      sv_q  <= '0;
      for (int i = 0; i < 3; i++) rb_q[i] <= '0;
    end else if (tick_i) begin
      ph_q  <= ph_d;
      op_q  <= op_d;
      bc_q  <= bc_d;
      dc_q  <= dc_d;
      sr_q  <= sr_d;
      bi_q  <= bi_d;
      err_q <= err_d;
      sv_q  <= sv_d;
      for (int i = 0; i < 3; i++) rb_q[i] <= rb_d[i];
    end
  end

  always_comb begin
    res_o.sck            = sck;
    res_o.data_drive_low = drv;
    res_o.busy_res       = (ph_d != PH_IDLE);
    res_o.done_res       = fire && (ph_d == PH_IDLE);
    res_o.error_count    = err_d;
    res_o.first_byte     = rb_d[0];
    res_o.second_byte    = rb_d[1];
    res_o.checksum_byte  = rb_d[2];
  end

endmodule

[hw/rtl/tws_out_buf.sv]
module tws_out_buf import tws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_i,
  output result_t data_o
);

  // output register plus one skid entry
  logic    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  result_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop_i) begin
      out_vld_d = skid_vld_q;
      out_d     = skid_q;
      skid_vld_d = 1'b0;
    end
    if (push_i) begin
      if (!out_vld_d) begin
        out_vld_d = 1'b1;
        out_d     = data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

[hw/rtl/two_wire_sensor_bus_master.sv]
// channel    dir  handshake      payload
// in_chan_i  in   valid/ready    start_req, func, status_value, data_in
// out_chan_o out  valid/ready    sck, data_drive_low, busy_res, done_res, error_count,
//                                first_byte, second_byte, checksum_byte
// cfg_chan_i in   valid/ready    index, data (ready is always high)
//
// One request per clock while the skid entry is free; each request is one bus tick and
// yields one result, kept in the output register or, if that is full, the skid entry.
// Output register plus a skid entry: input stalls only when both are full.
// rst_ni clears sequencer, config (to defaults) and the output valid flags.
module two_wire_sensor_bus_master import tws_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  tws_in_if.sink       in_chan_i,
  tws_out_if.source    out_chan_o,
  tws_cfg_if.sink      cfg_chan_i
);

  cfg_t    cfg;
  result_t res, res_q;
  logic    tick, buf_ready;

  assign cfg_chan_i.ready = 1'b1;
  assign in_chan_i.ready  = buf_ready;
  assign tick             = in_chan_i.valid && buf_ready;

  tws_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_chan_i.valid),
    .idx_i  (cfg_chan_i.index),
    .data_i (cfg_chan_i.data),
    .cfg_o  (cfg)
  );

  tws_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .tick_i         (tick),
    .start_req_i    (in_chan_i.start_req),
    .func_i         (in_chan_i.func),
    .status_value_i (in_chan_i.status_value),
    .data_in_i      (in_chan_i.data_in),
    .res_o          (res)
  );

  tws_out_buf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tick),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_chan_o.valid),
    .pop_i   (out_chan_o.valid && out_chan_o.ready),
    .data_o  (res_q)
  );

  assign out_chan_o.sck            = res_q.sck;
  assign out_chan_o.data_drive_low = res_q.data_drive_low;
  assign out_chan_o.busy_res       = res_q.busy_res;
  assign out_chan_o.done_res       = res_q.done_res;
  assign out_chan_o.error_count    = res_q.error_count;
  assign out_chan_o.first_byte     = res_q.first_byte;
  assign out_chan_o.second_byte    = res_q.second_byte;
  assign out_chan_o.checksum_byte  = res_q.checksum_byte;

endmodule
